@@ sv/che_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// che_pkg
// Shared types and constants for the clipped histogram equalizer.
// ---------------------------------------------------------------------------
package che_pkg;

    localparam int LEVELS      = 256;
    localparam int LVL_W       = 8;
    localparam int LVL_CNT_W   = 9;
    localparam int CNT_W       = 21;
    localparam int NUM_W       = 29;
    localparam int STEP_W      = 3;
    localparam logic [CNT_W-1:0] MAX_PIXELS = 21'd1048576;
    localparam logic [7:0] FULL_SCALE = 8'd255;
    localparam logic [8:0] MAX_LIGHT_RST = 9'd160;
    localparam logic [8:0] LEVELS_9 = 9'd256;

    typedef enum logic {
        MODE_COUNT = 1'b0,
        MODE_MAP   = 1'b1
    } mode_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] pixel;
    } in_item_t;

    typedef struct packed {
        logic [7:0] mapped_pixel;
        logic       degenerate;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CNT_WR,
        S_BLD_BASE,
        S_BLD_RD,
        S_BLD_ACC,
        S_BLD_MUL,
        S_BLD_DIV,
        S_BLD_WR,
        S_MAP_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic cnt_rd;
        logic cnt_wr;
        logic bld_init;
        logic bld_base;
        logic bld_rd;
        logic bld_acc;
        logic bld_mul;
        logic bld_div;
        logic bld_wr;
        logic set_ready;
        logic map_rd_in;
        logic map_rd_lat;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic tbl_ready;
        logic total_full;
        logic lvl_done;
        logic lvl_active;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

@@ sv/che_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// che_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module che_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/che_ctrl.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// che_ctrl
// Sequencer for counting, table build and lookup.
// ---------------------------------------------------------------------------
module che_ctrl
    import che_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire logic     in_mode,
    input  wire sts_t     sts,
    output cmd_t          cmd
);

    state_t state_reg, state_next;
    logic   acc;

    assign in_ready = (state_reg == S_IDLE);
    assign acc      = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (in_mode == MODE_COUNT)
                    begin
                        state_next = sts.total_full ? S_IDLE : S_CNT_WR;
                    end
                    else
                    begin
                        state_next = sts.tbl_ready ? S_MAP_OUT : S_BLD_BASE;
                    end
                end
            end
            S_CNT_WR:   state_next = S_IDLE;
            S_BLD_BASE: state_next = S_BLD_RD;
            S_BLD_RD:   state_next = sts.lvl_done ? S_MAP_OUT : S_BLD_ACC;
            S_BLD_ACC:  state_next = sts.lvl_active ? S_BLD_MUL : S_BLD_WR;
            S_BLD_MUL:  state_next = S_BLD_DIV;
            S_BLD_DIV:  state_next = sts.div_last ? S_BLD_WR : S_BLD_DIV;
            S_BLD_WR:   state_next = S_BLD_RD;
            S_MAP_OUT:  state_next = sts.out_free ? S_IDLE : S_MAP_OUT;
            default:    state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = acc;
                if (acc)
                begin
                    if (in_mode == MODE_COUNT)
                    begin
                        cmd.cnt_rd = !sts.total_full;
                    end
                    else if (sts.tbl_ready)
                    begin
                        cmd.map_rd_in = 1'b1;
                    end
                    else
                    begin
                        cmd.bld_init = 1'b1;
                    end
                end
            end
            S_CNT_WR:   cmd.cnt_wr   = 1'b1;
            S_BLD_BASE: cmd.bld_base = 1'b1;
            S_BLD_RD:
            begin
                if (sts.lvl_done)
                begin
                    cmd.set_ready  = 1'b1;
                    cmd.map_rd_lat = 1'b1;
                end
                else
                begin
                    cmd.bld_rd = 1'b1;
                end
            end
            S_BLD_ACC:  cmd.bld_acc  = 1'b1;
            S_BLD_MUL:  cmd.bld_mul  = 1'b1;
            S_BLD_DIV:  cmd.bld_div  = 1'b1;
            S_BLD_WR:   cmd.bld_wr   = 1'b1;
            S_MAP_OUT:  cmd.out_load = sts.out_free;
            default:    cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ sv/che_dp.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// che_dp
// Histogram, table build arithmetic, lookup and result register.
// ---------------------------------------------------------------------------
module che_dp
    import che_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire in_item_t   in_data,
    input  wire logic       cfg_wr_en,
    input  wire logic [8:0] cfg_wr_data,
    input  wire cmd_t       cmd,
    output sts_t            sts,
    output logic            out_valid,
    input  wire logic       out_ready,
    output out_item_t       out_data
);

    logic [8:0]           max_light_reg;
    logic                 ready_reg;
    logic                 dz_reg;
    logic [CNT_W-1:0]     total_reg;
    logic [LEVELS-1:0]    hvld_reg;
    logic                 hvld_rd_reg;
    logic [LVL_W-1:0]     pix_reg;
    logic [LVL_CNT_W-1:0] lvl_reg;
    logic [8:0]           limit_reg;
    logic [CNT_W-1:0]     base_reg;
    logic [CNT_W-1:0]     divisor_reg;
    logic [CNT_W-1:0]     running_reg;
    logic [NUM_W-1:0]     rem_reg;
    logic [7:0]           q_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 out_valid_reg;
    out_item_t            out_reg;

    logic                 h_re, h_we;
    logic [LVL_W-1:0]     h_raddr;
    logic [CNT_W-1:0]     h_rdata, h_wdata, h_val;
    logic                 t_re, t_we;
    logic [LVL_W-1:0]     t_raddr, t_waddr;
    logic [7:0]           t_rdata, t_wdata;
    logic                 clr;
    logic [NUM_W-1:0]     trial;
    logic [CNT_W-1:0]     base_next;

    che_ram #(.WIDTH(CNT_W), .DEPTH(LEVELS)) u_hist (
        .clk  (clk),
        .we   (h_we),
        .waddr(pix_reg),
        .wdata(h_wdata),
        .re   (h_re),
        .raddr(h_raddr),
        .rdata(h_rdata)
    );

    che_ram #(.WIDTH(8), .DEPTH(LEVELS)) u_tbl (
        .clk  (clk),
        .we   (t_we),
        .waddr(t_waddr),
        .wdata(t_wdata),
        .re   (t_re),
        .raddr(t_raddr),
        .rdata(t_rdata)
    );

    // new frame: a count beat while the table is live wipes the histogram
    assign clr = cmd.accept && (in_data.mode == MODE_COUNT) && ready_reg;

    // histogram port muxing
    assign h_re    = cmd.cnt_rd || cmd.bld_init || cmd.bld_rd;
    assign h_raddr = cmd.cnt_rd ? in_data.pixel :
                     (cmd.bld_rd ? lvl_reg[LVL_W-1:0] : '0);
    assign h_val   = hvld_rd_reg ? h_rdata : '0;
    assign h_we    = cmd.cnt_wr;
    assign h_wdata = h_val + CNT_W'(1);

    // table port muxing
    assign t_re    = cmd.map_rd_in || cmd.map_rd_lat;
    assign t_raddr = cmd.map_rd_in ? in_data.pixel : pix_reg;
    assign t_we    = cmd.bld_wr;
    assign t_waddr = lvl_reg[LVL_W-1:0];
    assign t_wdata = (lvl_reg < limit_reg && !dz_reg) ? q_reg : '0;

    assign trial     = NUM_W'(divisor_reg) << step_reg;
    assign base_next = (limit_reg != '0) ? h_val : '0;

    // status
    assign sts.tbl_ready  = ready_reg;
    assign sts.total_full = !ready_reg && (total_reg >= MAX_PIXELS);
    assign sts.lvl_done   = (lvl_reg == LEVELS_9);
    assign sts.lvl_active = (lvl_reg < limit_reg) && !dz_reg;
    assign sts.div_last   = (step_reg == '0);
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_light_reg <= MAX_LIGHT_RST;
            ready_reg     <= 1'b0;
            dz_reg        <= 1'b0;
            total_reg     <= '0;
            hvld_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_light_reg <= cfg_wr_data;
            end
            if (clr)
            begin
                ready_reg <= 1'b0;
                total_reg <= '0;
                hvld_reg  <= '0;
            end
            if (cmd.cnt_wr)
            begin
                total_reg         <= total_reg + CNT_W'(1);
                hvld_reg[pix_reg] <= 1'b1;
            end
            if (cmd.set_ready)
            begin
                ready_reg <= 1'b1;
            end
            if (cmd.bld_base)
            begin
                dz_reg <= (total_reg <= base_next);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (h_re)
        begin
            hvld_rd_reg <= hvld_reg[h_raddr] && !clr;
        end
        if (cmd.accept)
        begin
            pix_reg <= in_data.pixel;
        end
        if (cmd.bld_init)
        begin
            lvl_reg     <= '0;
            running_reg <= '0;
            limit_reg   <= (max_light_reg > LEVELS_9) ? LEVELS_9 : max_light_reg;
        end
        if (cmd.bld_base)
        begin
            base_reg    <= base_next;
            divisor_reg <= (total_reg <= base_next) ? '0 : total_reg - base_next;
        end
        if (cmd.bld_acc)
        begin
            running_reg <= running_reg + h_val;
        end
        // numerator (cdf - base) * 255; quotient always fits 8 bits
        if (cmd.bld_mul)
        begin
            rem_reg  <= NUM_W'(running_reg - base_reg) * NUM_W'(FULL_SCALE);
            q_reg    <= '0;
            step_reg <= STEP_W'(7);
        end
        // restoring divide, one quotient bit per cycle
        if (cmd.bld_div)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg          <= rem_reg - trial;
                q_reg[step_reg]  <= 1'b1;
            end
            step_reg <= step_reg - STEP_W'(1);
        end
        if (cmd.bld_wr)
        begin
            lvl_reg <= lvl_reg + LVL_CNT_W'(1);
        end
        if (cmd.out_load)
        begin
            out_reg.mapped_pixel <= dz_reg ? '0 : t_rdata;
            out_reg.degenerate   <= dz_reg;
        end
    end

endmodule

`default_nettype wire

@@ sv/clipped_histogram_equalizer.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// clipped_histogram_equalizer
// Two-phase 8-bit grey level equalizer with clipping of bright levels.
// ---------------------------------------------------------------------------
// Count beats (mode 0) add a pixel to a 256-bin histogram and give no result;
// each does a read-modify-write of the histogram RAM, or is not counted when the
// frame already holds MAX_PIXELS. The first count beat after mapping starts a
// new frame. The first map beat after counting builds the 256-entry lookup
// table: setup of the base and divisor, then per level a read and accumulate and
// either a plain write (clipped or degenerate) or a multiply and 8-step
// restoring divide before the write. Other map beats read the table RAM, then
// load the result register. The result register lets the next beat be taken
// while a result waits. max_light is sampled at table build only.
module clipped_histogram_equalizer
    import che_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire in_item_t   in_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output out_item_t       out_data,
    input  wire logic       cfg_wr_en,
    input  wire logic [8:0] cfg_wr_data
);

    cmd_t cmd;
    sts_t sts;

    che_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_mode (in_data.mode),
        .sts     (sts),
        .cmd     (cmd)
    );

    che_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_data    (in_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire
